// ===== rtl/core/sst_pkg.sv =====
// Shared types, constants and helper functions of the swerve steering target optimiser.
package sst_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CPR      = 2'd0,
    REG_DEADBAND = 2'd1,
    REG_ERPM_K   = 2'd2
  } cfg_reg_t;

  localparam logic [20:0] CPR_RESET      = 21'd8192;
  localparam logic [14:0] DEADBAND_RESET = 15'd50;
  localparam logic [31:0] ERPM_K_RESET   = 32'd65536;

  // Angles are held in hundredths of a degree times the counts per revolution.
  localparam logic [36:0] UNITS_PER_COUNT = 37'd36000;
  localparam logic [36:0] HALF_TURN_HUND  = 37'd18000;
  localparam logic [36:0] FOLD_LIMIT_HUND = 37'd9500;

  localparam logic signed [17:0] ANG_TURN = 18'sd36000;

  // Pipelined remainder: four quotient bits per stage over the 32-bit magnitude.
  localparam int unsigned ENC_W      = 32;
  localparam int unsigned MOD_BITS   = 4;
  localparam int unsigned MOD_STAGES = ENC_W / MOD_BITS;

  // Division by 36000 is a shift by five and a reciprocal multiply for 1125.
  localparam logic [31:0]        RECIP_1125 = 32'd3909374677;
  localparam int unsigned        RECIP_SH   = 42;
  localparam logic [31:0]        DIV_1125   = 32'd1125;
  localparam logic signed [38:0] DIV_OFFSET = 39'sd1179648000;
  localparam logic signed [22:0] Q_OFFSET   = 23'sd1048576;

  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  typedef struct packed {
    logic [20:0] cpr;
    logic [14:0] deadband;
    logic [31:0] erpm_k;
    logic [36:0] period;
    logic [36:0] half;
    logic [36:0] lim;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         wheel;
    logic signed [31:0] enc;
    logic               neg;
    logic [31:0]        dvd;
    logic [20:0]        rem;
    logic [15:0]        ang;
    logic               drive_on;
    logic               spd_neg;
    logic [15:0]        spd_mag;
    logic [30:0]        emag;
    logic signed [21:0] h;
    logic [36:0]        ac;
    logic signed [38:0] x;
    logic               rev;
    logic [31:0]        u;
    logic               low_nz;
    logic [21:0]        q;
    logic               rnz;
    logic signed [33:0] tsum;
    logic signed [31:0] erpm;
  } pipe_t;

  // Target angle reduced into [0, 36000).
  function automatic logic [15:0] ang_wrap(input logic signed [16:0] ang);
    logic signed [17:0] a;
    logic signed [17:0] t;
    a = 18'(ang);
    if (a < -ANG_TURN) begin
      t = a + 18'(2 * ANG_TURN);
    end else if (a < 18'sd0) begin
      t = a + ANG_TURN;
    end else if (a >= ANG_TURN) begin
      t = a - ANG_TURN;
    end else begin
      t = a;
    end
    return t[15:0];
  endfunction

  // Four restoring remainder steps; rem stays below div.
  function automatic logic [20:0] mod_step(input logic [20:0] rem, input logic [3:0] bits,
                                           input logic [20:0] div);
    logic [21:0] t;
    logic [20:0] r;
    r = rem;
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i[1:0]]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = t[20:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sst_if.sv =====
// Channel interfaces of the steering target optimiser: command, result and configuration.
interface sst_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [1:0]         wheel_select;
  logic signed [31:0] encoder_total;
  logic signed [15:0] target_speed;
  logic signed [16:0] target_angle;

  modport source (output valid, cmd, wheel_select, encoder_total, target_speed, target_angle,
                  input ready);
  modport sink (input valid, cmd, wheel_select, encoder_total, target_speed, target_angle,
                output ready);
endinterface

interface sst_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         wheel_select_out;
  logic signed [31:0] steer_target;
  logic signed [31:0] drive_erpm;
  logic               drive_reversed;

  modport source (output valid, wheel_select_out, steer_target, drive_erpm, drive_reversed,
                  input ready);
  modport sink (input valid, wheel_select_out, steer_target, drive_erpm, drive_reversed,
                output ready);
endinterface

interface sst_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sst_cfg.sv =====
// Configuration registers and the per-revolution products derived from them.
module sst_cfg (
  input  logic          clk,
  input  logic          rst_n,
  sst_cfg_if.sink       cfg_ch,
  output sst_pkg::cfg_t cfg
);
  import sst_pkg::*;

  logic [20:0] cpr_r;
  logic [14:0] db_r;
  logic [31:0] ek_r;
  logic [36:0] period_r;
  logic [36:0] half_r;
  logic [36:0] lim_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r <= CPR_RESET;
      db_r  <= DEADBAND_RESET;
      ek_r  <= ERPM_K_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_CPR: begin
          // A zero revolution size behaves as one count.
          cpr_r <= (cfg_ch.data[20:0] == 21'd0) ? 21'd1 : cfg_ch.data[20:0];
        end
        REG_DEADBAND: db_r <= cfg_ch.data[14:0];
        REG_ERPM_K:   ek_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // The products are registered from the revolution size and follow it in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 37'(37'(CPR_RESET) * UNITS_PER_COUNT);
      half_r   <= 37'(37'(CPR_RESET) * HALF_TURN_HUND);
      lim_r    <= 37'(37'(CPR_RESET) * FOLD_LIMIT_HUND);
    end else begin
      period_r <= 37'(37'(cpr_r) * UNITS_PER_COUNT);
      half_r   <= 37'(37'(cpr_r) * HALF_TURN_HUND);
      lim_r    <= 37'(37'(cpr_r) * FOLD_LIMIT_HUND);
    end
  end

  assign cfg.cpr      = cpr_r;
  assign cfg.deadband = db_r;
  assign cfg.erpm_k   = ek_r;
  assign cfg.period   = period_r;
  assign cfg.half     = half_r;
  assign cfg.lim      = lim_r;

endmodule

// ===== rtl/core/sst_mod.sv =====
// Pipelined remainder of the encoder magnitude by the counts per revolution.
module sst_mod (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [20:0]    cpr,
  input  logic           up_valid,
  output logic           up_ready,
  input  sst_pkg::pipe_t up_pipe,
  output logic           dn_valid,
  input  logic           dn_ready,
  output sst_pkg::pipe_t dn_pipe
);
  import sst_pkg::*;

  logic  v_r   [MOD_STAGES];
  pipe_t p_r   [MOD_STAGES];
  logic  src_v [MOD_STAGES];
  pipe_t src_p [MOD_STAGES];
  logic  ld    [MOD_STAGES+1];
  pipe_t p_nxt [MOD_STAGES];

  assign ld[MOD_STAGES] = dn_ready;

  for (genvar k = 0; k < MOD_STAGES; k++) begin : g_st
    if (k == 0) begin : g_first
      assign src_v[k] = up_valid;
      assign src_p[k] = up_pipe;
    end else begin : g_next
      assign src_v[k] = v_r[k-1];
      assign src_p[k] = p_r[k-1];
    end

    // A stage loads when it is empty or its content moves on in the same cycle.
    assign ld[k] = !v_r[k] || ld[k+1];

    always_comb begin
      p_nxt[k]     = src_p[k];
      p_nxt[k].rem = mod_step(src_p[k].rem, src_p[k].dvd[ENC_W-1 -: MOD_BITS], cpr);
      p_nxt[k].dvd = src_p[k].dvd << MOD_BITS;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        p_r[k] <= p_nxt[k];
      end
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = v_r[MOD_STAGES-1];
  assign dn_pipe  = p_r[MOD_STAGES-1];

endmodule

// ===== rtl/core/sst_delta.sv =====
// Heading, shortest delta, fold, drive ERPM and the division of the delta by one count.
module sst_delta (
  input  logic           clk,
  input  logic           rst_n,
  input  sst_pkg::cfg_t  cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  sst_pkg::pipe_t up_pipe,
  output logic           dn_valid,
  input  logic           dn_ready,
  output sst_pkg::pipe_t dn_pipe
);
  import sst_pkg::*;

  localparam int unsigned NST  = 7;
  localparam int unsigned ST_H = 0;
  localparam int unsigned ST_X = 1;
  localparam int unsigned ST_W = 2;
  localparam int unsigned ST_F = 3;
  localparam int unsigned ST_Q = 4;
  localparam int unsigned ST_P = 5;
  localparam int unsigned ST_R = 6;

  logic  v_r   [NST];
  pipe_t p_r   [NST];
  pipe_t p_nxt [NST];
  logic  src_v [NST];
  logic  ld    [NST+1];

  logic [20:0]        r_fix;
  logic signed [38:0] half_s;
  logic signed [38:0] period_s;
  logic signed [38:0] lim_s;
  logic [47:0]        eprod;
  logic signed [38:0] u_wide;
  logic [63:0]        qprod;
  logic [31:0]        qback;
  logic signed [22:0] fq;

  assign half_s   = $signed({2'b00, cfg.half});
  assign period_s = $signed({2'b00, cfg.period});
  assign lim_s    = $signed({2'b00, cfg.lim});

  // Heading within [-cpr/2, cpr/2), and the target angle times the counts per revolution.
  always_comb begin
    p_nxt[ST_H] = up_pipe;
    r_fix = (up_pipe.neg && up_pipe.rem != 21'd0) ? cfg.cpr - up_pipe.rem : up_pipe.rem;
    if ({r_fix, 1'b0} >= {1'b0, cfg.cpr}) begin
      p_nxt[ST_H].h = $signed({1'b0, r_fix}) - $signed({1'b0, cfg.cpr});
    end else begin
      p_nxt[ST_H].h = $signed({1'b0, r_fix});
    end
    p_nxt[ST_H].ac = 37'(up_pipe.ang) * 37'(cfg.cpr);
  end

  always_comb begin
    p_nxt[ST_X]   = p_r[ST_H];
    p_nxt[ST_X].x = $signed({2'b00, p_r[ST_H].ac}) - (39'(p_r[ST_H].h) * 39'sd36000);
  end

  // The raw delta lies within (-half, period + half): one subtraction brings it into range.
  always_comb begin
    p_nxt[ST_W] = p_r[ST_X];
    if (p_r[ST_X].x > half_s) begin
      p_nxt[ST_W].x = p_r[ST_X].x - period_s;
    end
    eprod            = 48'(p_r[ST_X].spd_mag) * 48'(cfg.erpm_k);
    p_nxt[ST_W].emag = eprod[46:16];
  end

  always_comb begin
    p_nxt[ST_F] = p_r[ST_W];
    if (!p_r[ST_W].cmd) begin
      priority if (p_r[ST_W].x > lim_s) begin
        p_nxt[ST_F].x   = p_r[ST_W].x - half_s;
        p_nxt[ST_F].rev = 1'b1;
      end else if (p_r[ST_W].x < -lim_s) begin
        p_nxt[ST_F].x   = p_r[ST_W].x + half_s;
        p_nxt[ST_F].rev = 1'b1;
      end else begin
        p_nxt[ST_F].rev = 1'b0;
      end
    end
  end

  // Floor division by 32 first; the offset keeps the dividend of the reciprocal positive.
  always_comb begin
    p_nxt[ST_Q]        = p_r[ST_F];
    u_wide             = (p_r[ST_F].x >>> 5) + DIV_OFFSET;
    p_nxt[ST_Q].u      = u_wide[31:0];
    p_nxt[ST_Q].low_nz = p_r[ST_F].x[4:0] != 5'd0;
    if (!p_r[ST_F].drive_on) begin
      p_nxt[ST_Q].erpm = 32'sd0;
    end else if (p_r[ST_F].spd_neg ^ p_r[ST_F].rev) begin
      p_nxt[ST_Q].erpm = -$signed({1'b0, p_r[ST_F].emag});
    end else begin
      p_nxt[ST_Q].erpm = $signed({1'b0, p_r[ST_F].emag});
    end
  end

  always_comb begin
    p_nxt[ST_P]   = p_r[ST_Q];
    qprod         = 64'(p_r[ST_Q].u) * 64'(RECIP_1125);
    p_nxt[ST_P].q = qprod[63:RECIP_SH];
  end

  always_comb begin
    p_nxt[ST_R]      = p_r[ST_P];
    qback            = 32'(p_r[ST_P].q) * DIV_1125;
    p_nxt[ST_R].rnz  = p_r[ST_P].low_nz || (p_r[ST_P].u != qback);
    fq               = $signed({1'b0, p_r[ST_P].q}) - Q_OFFSET;
    p_nxt[ST_R].tsum = 34'(p_r[ST_P].enc) + 34'(fq);
  end

  assign src_v[0] = up_valid;
  assign ld[NST]  = dn_ready;

  for (genvar k = 0; k < NST; k++) begin : g_st
    if (k > 0) begin : g_src
      assign src_v[k] = v_r[k-1];
    end

    assign ld[k] = !v_r[k] || ld[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        p_r[k] <= p_nxt[k];
      end
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = v_r[NST-1];
  assign dn_pipe  = p_r[NST-1];

endmodule

// ===== rtl/core/swerve_steer_target_optimizer_unit.sv =====
// Top level of the swerve steering target optimiser.
//
//   Channel  Direction  Beat contents
//   in_ch    sink       cmd, wheel_select, encoder_total, target_speed, target_angle
//   out_ch   source     wheel_select_out, steer_target, drive_erpm, drive_reversed
//   cfg_ch   sink       index, data (always ready)
//
// One beat enters per cycle while out_ch does not stall; a result passes the input stage, the
// eight remainder stages (four bits each) and the delta stages with the reciprocal division.
// Every stage carries a valid bit and loads when empty or when its content moves on, so a
// stall on out_ch fills bubbles first and loses nothing. Reset is synchronous and active low;
// it empties the pipeline and restores the configuration registers.
module swerve_steer_target_optimizer_unit (
  input  logic      clk,
  input  logic      rst_n,
  sst_in_if.sink    in_ch,
  sst_out_if.source out_ch,
  sst_cfg_if.sink   cfg_ch
);
  import sst_pkg::*;

  cfg_t  cfg;
  logic  v0_r;
  pipe_t p0_r;
  pipe_t p0_nxt;
  logic  ld0;
  logic  mod_ready;
  logic  mod_valid;
  pipe_t mod_pipe;
  logic  dl_ready;
  logic  dl_valid;
  pipe_t dl_pipe;
  logic  ldt;

  logic signed [16:0] spd_x;
  logic signed [16:0] spd_abs;
  logic [31:0]        enc_u;
  logic signed [33:0] tg;

  logic               vt_r;
  logic [1:0]         wheel_r;
  logic signed [31:0] tgt_r;
  logic signed [31:0] erpm_r;
  logic               rev_r;
  logic signed [31:0] tgt_nxt;

  sst_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Input stage: magnitudes, the wrapped target angle and the deadband decision.
  always_comb begin
    spd_x   = 17'(in_ch.target_speed);
    spd_abs = spd_x[16] ? -spd_x : spd_x;
    enc_u   = in_ch.encoder_total;

    p0_nxt          = '0;
    p0_nxt.cmd      = in_ch.cmd;
    p0_nxt.wheel    = in_ch.wheel_select;
    p0_nxt.enc      = in_ch.encoder_total;
    p0_nxt.neg      = enc_u[31];
    p0_nxt.dvd      = enc_u[31] ? (~enc_u + 32'd1) : enc_u;
    p0_nxt.ang      = ang_wrap(in_ch.target_angle);
    p0_nxt.spd_neg  = spd_x[16];
    p0_nxt.spd_mag  = spd_abs[15:0];
    p0_nxt.drive_on = !in_ch.cmd && (spd_abs[15:0] >= {1'b0, cfg.deadband});
  end

  assign ld0         = !v0_r || mod_ready;
  assign in_ch.ready = ld0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ld0) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      p0_r <= p0_nxt;
    end
  end

  sst_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .cpr      (cfg.cpr),
    .up_valid (v0_r),
    .up_ready (mod_ready),
    .up_pipe  (p0_r),
    .dn_valid (mod_valid),
    .dn_ready (dl_ready),
    .dn_pipe  (mod_pipe)
  );

  sst_delta u_delta (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (mod_valid),
    .up_ready (dl_ready),
    .up_pipe  (mod_pipe),
    .dn_valid (dl_valid),
    .dn_ready (ldt),
    .dn_pipe  (dl_pipe)
  );

  // Truncation toward zero: a negative sum with a remainder moves up by one.
  always_comb begin
    tg = dl_pipe.tsum + $signed({33'd0, (dl_pipe.tsum < 34'sd0) && dl_pipe.rnz});
    priority if (tg > SAT_MAX) begin
      tgt_nxt = SAT_MAX[31:0];
    end else if (tg < SAT_MIN) begin
      tgt_nxt = SAT_MIN[31:0];
    end else begin
      tgt_nxt = tg[31:0];
    end
  end

  assign ldt = !vt_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (ldt) begin
      vt_r <= dl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ldt) begin
      wheel_r <= dl_pipe.wheel;
      tgt_r   <= tgt_nxt;
      erpm_r  <= dl_pipe.erpm;
      rev_r   <= dl_pipe.rev;
    end
  end

  assign out_ch.valid            = vt_r;
  assign out_ch.wheel_select_out = wheel_r;
  assign out_ch.steer_target     = tgt_r;
  assign out_ch.drive_erpm       = erpm_r;
  assign out_ch.drive_reversed   = rev_r;

endmodule

// ===== rtl/core/sst_chk.sv =====
// Port-level checker of the steering target optimiser and its bind to the top level.
module sst_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_wheel,
  input logic [31:0] out_tgt,
  input logic [31:0] out_erpm,
  input logic        out_rev
);

  localparam int unsigned DEPTH = 17;

  logic [4:0] cnt_r;
  logic [4:0] cnt_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 5'd1;
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wheel) && $stable(out_tgt) &&
                                $stable(out_erpm) && $stable(out_rev))
    else $error("stalled result beat changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 5'd0)
    else $error("result beat without an outstanding command");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(DEPTH))
    else $error("more commands in flight than pipeline stages");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 5'd0 |-> in_ready)
    else $error("empty pipeline refuses a command");

endmodule

bind swerve_steer_target_optimizer_unit sst_chk u_sst_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_wheel (out_ch.wheel_select_out),
  .out_tgt   (out_ch.steer_target),
  .out_erpm  (out_ch.drive_erpm),
  .out_rev   (out_ch.drive_reversed)
);
